>>> sv/dmscq_pkg.sv
// Shared types and constants of the deferred multi-stack command queue.
// No dependencies; imported by every module of the block.
package dmscq_pkg;

  localparam int NUM_STACKS_DEF  = 8;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int RES_CNT_W       = $clog2(MAX_RESULTS);

  localparam logic [3:0] ACTIVE_RESET = 4'd8;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_DRAIN = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    STAT_QUEUED     = 3'd0,
    STAT_BAD_INDEX  = 3'd1,
    STAT_QUEUE_FULL = 3'd2,
    STAT_PUSHED     = 3'd3,
    STAT_POPPED     = 3'd4,
    STAT_POP_EMPTY  = 3'd5,
    STAT_PUSH_FULL  = 3'd6,
    STAT_NOTHING    = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMD,
    S_POP
  } state_t;

endpackage

>>> sv/dmscq_stack_bank.sv
// Stack bank: per-stack heights in flip-flops and one word memory for all stacks.
// Depends on dmscq_pkg for the status codes.
module dmscq_stack_bank #(
  parameter int NUM_STACKS  = dmscq_pkg::NUM_STACKS_DEF,
  parameter int STACK_DEPTH = dmscq_pkg::STACK_DEPTH_DEF,
  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                op_en,
  input  logic                op_pop,
  input  logic [SW-1:0]       op_stack,
  input  logic signed [31:0]  op_word,
  output dmscq_pkg::status_t  op_status,
  output logic signed [31:0]  rd_word
);
  import dmscq_pkg::*;

  localparam int HW = $clog2(STACK_DEPTH + 1);
  localparam int MD = NUM_STACKS * STACK_DEPTH;
  localparam int AW = $clog2(MD);

  logic [HW-1:0]      heights_r [NUM_STACKS];
  logic signed [31:0] words_mem [MD];
  logic [HW-1:0]      h;
  logic [HW-1:0]      h_slot;
  logic [AW-1:0]      addr;
  logic               empty;
  logic               full;

  always_comb begin
    h      = heights_r[op_stack];
    empty  = (h == '0);
    full   = (h == HW'(STACK_DEPTH));
    h_slot = op_pop ? (h - HW'(1)) : h;
    addr   = AW'(AW'(op_stack) * AW'(STACK_DEPTH) + AW'(h_slot));
    if (op_pop) begin
      op_status = empty ? STAT_POP_EMPTY : STAT_POPPED;
    end else begin
      op_status = full ? STAT_PUSH_FULL : STAT_PUSHED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        heights_r[i] <= '0;
      end
    end else if (op_en) begin
      if (op_pop && !empty) begin
        heights_r[op_stack] <= h - HW'(1);
      end else if (!op_pop && !full) begin
        heights_r[op_stack] <= h + HW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_en && !op_pop && !full) begin
      words_mem[addr] <= op_word;
    end
    if (op_en && op_pop && !empty) begin
      rd_word <= words_mem[addr];
    end
  end

endmodule

>>> sv/deferred_multi_stack_command_queue_top.sv
// Top level of the deferred multi-stack command queue: command FIFO memory,
// drain sequencer and output register. Depends on dmscq_pkg and dmscq_stack_bank.
//
// Input channel (in_valid/in_stall) carries one transaction per item: an enqueue
// (mode push or pop) or a drain. Result channel (out_valid/out_stall) carries
// the results; out_last marks the final result of each input transaction.
// An enqueue, a rejected enqueue or an empty drain gives one result, registered
// in the cycle after acceptance. A drain applies up to 16 queued commands in
// order: a push or a pop on an empty stack is answered from state S_CMD, a pop
// that returns a word goes on to S_POP to take the read of the stack word memory.
// The command memory is read into a register before the first command of a drain.
// A new input transaction is taken once the previous one has issued its last
// result and the output register is free or being emptied.
// A stall on the result channel holds the output register and freezes the
// drain at the next result; nothing is lost.
// Reset empties the queue and all stacks and sets active_stacks to 8. cfg_write_en
// writes active_stacks; user writes only while the block is idle, not enforced.
module deferred_multi_stack_command_queue_top #(
  parameter int NUM_STACKS  = dmscq_pkg::NUM_STACKS_DEF,
  parameter int STACK_DEPTH = dmscq_pkg::STACK_DEPTH_DEF,
  parameter int QUEUE_DEPTH = dmscq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  logic [3:0]         cfg_write_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [3:0]         in_stack_index,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [3:0]         out_target_stack,
  output logic signed [31:0] out_word,
  output logic [4:0]         out_pending_count,
  output logic               out_last
);
  import dmscq_pkg::*;

  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int CW = 1 + SW + 32;

  state_t state_r, state_nxt;
  logic [QW-1:0] head_r, head_nxt, tail_r, tail_nxt, head_inc;
  logic [FW-1:0] fill_r, fill_nxt, fill_dec;
  logic [RES_CNT_W-1:0] n_r, n_nxt;
  logic [3:0] active_r;

  logic [CW-1:0] cmd_mem [QUEUE_DEPTH];
  logic [CW-1:0] cmd_rd_r;
  logic          cmd_re, cmd_we;
  logic [QW-1:0] cmd_raddr;
  logic [CW-1:0] cmd_wdata;

  logic               cmd_pop;
  logic [SW-1:0]      cmd_stack;
  logic signed [31:0] cmd_word;
  logic [SW:0]        cmd_tgt;

  logic               bank_en;
  status_t            bank_status;
  logic signed [31:0] bank_rd_word;

  logic out_free, accept, enq_pop, bad_idx, step_last;

  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  status_t            out_status_r, out_status_nxt;
  logic [3:0]         out_tgt_r, out_tgt_nxt;
  logic signed [31:0] out_word_r, out_word_nxt;
  logic [4:0]         out_pend_r, out_pend_nxt;
  logic               out_last_r, out_last_nxt;

  assign {cmd_pop, cmd_stack, cmd_word} = cmd_rd_r;
  assign cmd_tgt  = {1'b0, cmd_stack} + (SW + 1)'(1);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign head_inc = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + QW'(1);
  assign fill_dec = fill_r - FW'(1);
  assign step_last = (fill_dec == '0) || (n_r == RES_CNT_W'(MAX_RESULTS - 1));
  assign enq_pop  = (in_mode == MODE_POP) || (in_value == '0);
  assign bad_idx  = (in_stack_index == 4'd0) || (in_stack_index > active_r) ||
                    (32'(in_stack_index) > NUM_STACKS);

  dmscq_stack_bank #(
    .NUM_STACKS  (NUM_STACKS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_en     (bank_en),
    .op_pop    (cmd_pop),
    .op_stack  (cmd_stack),
    .op_word   (cmd_word),
    .op_status (bank_status),
    .rd_word   (bank_rd_word)
  );

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fill_nxt       = fill_r;
    n_nxt          = n_r;
    cmd_re         = 1'b0;
    cmd_raddr      = head_r;
    cmd_we         = 1'b0;
    cmd_wdata      = {enq_pop, SW'(in_stack_index - 4'd1), enq_pop ? 32'sd0 : in_value};
    bank_en        = 1'b0;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_tgt_nxt    = out_tgt_r;
    out_word_nxt   = out_word_r;
    out_pend_nxt   = out_pend_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_PUSH, MODE_POP: begin
              out_load     = 1'b1;
              out_last_nxt = 1'b1;
              out_tgt_nxt  = 4'd0;
              out_word_nxt = '0;
              out_pend_nxt = 5'(fill_r);
              if (bad_idx) begin
                out_status_nxt = STAT_BAD_INDEX;
              end else if (fill_r == FW'(QUEUE_DEPTH)) begin
                out_status_nxt = STAT_QUEUE_FULL;
              end else begin
                cmd_we         = 1'b1;
                tail_nxt       = (tail_r == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + QW'(1);
                fill_nxt       = fill_r + FW'(1);
                out_status_nxt = STAT_QUEUED;
                out_tgt_nxt    = in_stack_index;
                out_word_nxt   = enq_pop ? 32'sd0 : in_value;
                out_pend_nxt   = 5'(fill_nxt);
              end
            end
            MODE_DRAIN: begin
              if (fill_r == '0) begin
                out_load       = 1'b1;
                out_status_nxt = STAT_NOTHING;
                out_tgt_nxt    = 4'd0;
                out_word_nxt   = '0;
                out_pend_nxt   = 5'd0;
                out_last_nxt   = 1'b1;
              end else begin
                cmd_re    = 1'b1;
                n_nxt     = '0;
                state_nxt = S_CMD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CMD: begin
        if (out_free) begin
          bank_en = 1'b1;
          if (bank_status == STAT_POPPED) begin
            state_nxt = S_POP;
          end else begin
            out_load       = 1'b1;
            out_status_nxt = bank_status;
            out_tgt_nxt    = 4'(cmd_tgt);
            out_word_nxt   = (bank_status == STAT_PUSHED) ? cmd_word : 32'sd0;
            out_pend_nxt   = 5'(fill_dec);
            out_last_nxt   = step_last;
            head_nxt       = head_inc;
            fill_nxt       = fill_dec;
            n_nxt          = n_r + RES_CNT_W'(1);
            cmd_raddr      = head_inc;
            cmd_re         = !step_last;
            state_nxt      = step_last ? S_IDLE : S_CMD;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = STAT_POPPED;
          out_tgt_nxt    = 4'(cmd_tgt);
          out_word_nxt   = bank_rd_word;
          out_pend_nxt   = 5'(fill_dec);
          out_last_nxt   = step_last;
          head_nxt       = head_inc;
          fill_nxt       = fill_dec;
          n_nxt          = n_r + RES_CNT_W'(1);
          cmd_raddr      = head_inc;
          cmd_re         = !step_last;
          state_nxt      = step_last ? S_IDLE : S_CMD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      n_r         <= '0;
      active_r    <= ACTIVE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write_en) begin
        active_r <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_tgt_r    <= out_tgt_nxt;
    out_word_r   <= out_word_nxt;
    out_pend_r   <= out_pend_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd_we) begin
      cmd_mem[tail_r] <= cmd_wdata;
    end
    if (cmd_re) begin
      cmd_rd_r <= cmd_mem[cmd_raddr];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_target_stack  = out_tgt_r;
  assign out_word          = out_word_r;
  assign out_pending_count = out_pend_r;
  assign out_last          = out_last_r;

endmodule
